[hdl/ale_pkg.sv]
// ----------------------------------------------------------------------------
// ale_pkg
// Types and constants shared by the array list engine modules.
// ----------------------------------------------------------------------------
package ale_pkg;

	localparam int DEPTH  = 16;
	localparam int CNT_W  = 5;
	localparam int IDX_W  = 4;
	localparam int ELEM_W = 32;

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_DELETE = 3'd1;
	localparam logic [2:0] CMD_READ   = 3'd2;
	localparam logic [2:0] CMD_FIND   = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_BADPOS   = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [2:0]              kind;
		logic [CNT_W-1:0]        position;
		logic signed [ELEM_W-1:0] value;
	} ale_in_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [ELEM_W-1:0] read_value;
		logic [IDX_W-1:0]         found_index;
		logic [CNT_W-1:0]         entry_count;
		logic                     is_empty;
	} ale_out_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ale_ctrl_t;

endpackage

[hdl/array_list_engine.sv]
// ----------------------------------------------------------------------------
// array_list_engine
// Ordered list of up to 16 entries driven by insert, delete, read, find and
// clear commands. A command is taken when start is high and busy is low;
// its result is registered after the execute step and appears for one cycle
// with done high, and cannot be held off. Each command is first registered
// and then executed on the register cells; no new command is taken while
// busy is high. Rejected commands leave the list unchanged and report a
// status code.
// ----------------------------------------------------------------------------
module array_list_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  ale_pkg::ale_in_t          cmd,
	output logic                      busy,
	output logic                      done,
	output ale_pkg::ale_out_t         result,
	input  logic                      cfg_we,
	input  logic [ale_pkg::CNT_W-1:0] cfg_wdata
);
	import ale_pkg::*;

	ale_ctrl_t ctrl;

	ale_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctrl   (ctrl)
	);

	ale_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

endmodule

[hdl/ale_ctrl.sv]
// ----------------------------------------------------------------------------
// ale_ctrl
// Controller: takes a command, runs the execute step, strobes the result.
// ----------------------------------------------------------------------------
module ale_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output ale_pkg::ale_ctrl_t ctrl
);
	import ale_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	assign busy      = busy_q;
	assign done      = done_q;
	assign ctrl.load = start && !busy_q;
	assign ctrl.exec = (state_q == S_RUN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_RUN;
						busy_q  <= 1'b1;
					end
				end
				S_RUN: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_run_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("execute cycle did not end in a result strobe");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe without a preceding execute cycle");

endmodule

[hdl/ale_dp.sv]
// ----------------------------------------------------------------------------
// ale_dp
// Datapath: list register cells, entry count, capacity register, result.
// ----------------------------------------------------------------------------
module ale_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ale_pkg::ale_ctrl_t        ctrl,
	input  ale_pkg::ale_in_t          cmd,
	input  logic                      cfg_we,
	input  logic [ale_pkg::CNT_W-1:0] cfg_wdata,
	output ale_pkg::ale_out_t         result
);
	import ale_pkg::*;

	ale_in_t           cmd_s1;
	logic [ELEM_W-1:0] cells_q [DEPTH];
	logic [ELEM_W-1:0] cells_nxt [DEPTH];
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_nxt;
	logic [CNT_W-1:0]  cap_q;
	logic [CNT_W-1:0]  eff_cap;
	logic              wr_en;
	logic              hit;
	logic              pos_ok;
	ale_out_t          res_nxt;
	ale_out_t          res_q;

	assign result  = res_q;
	assign eff_cap = (cap_q > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_q;
	assign pos_ok  = cmd_s1.position < count_q;

	always_comb begin
		cells_nxt           = cells_q;
		count_nxt           = count_q;
		wr_en               = 1'b0;
		hit                 = 1'b0;
		res_nxt.status      = ST_OK;
		res_nxt.read_value  = '0;
		res_nxt.found_index = '0;
		case (cmd_s1.kind)
			CMD_INSERT: begin
				if (count_q >= eff_cap) begin
					res_nxt.status = ST_FULL;
				end else if (cmd_s1.position > count_q) begin
					res_nxt.status = ST_BADPOS;
				end else begin
					wr_en = 1'b1;
					for (int i = 1; i < DEPTH; i++) begin
						if (CNT_W'(i) > cmd_s1.position) begin
							cells_nxt[i] = cells_q[i-1];
						end
					end
					for (int i = 0; i < DEPTH; i++) begin
						if (CNT_W'(i) == cmd_s1.position) begin
							cells_nxt[i] = cmd_s1.value;
						end
					end
					count_nxt = count_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				if (!pos_ok) begin
					res_nxt.status = ST_BADPOS;
				end else begin
					wr_en = 1'b1;
					for (int i = 0; i < DEPTH - 1; i++) begin
						if (CNT_W'(i) >= cmd_s1.position) begin
							cells_nxt[i] = cells_q[i+1];
						end
					end
					count_nxt = count_q - CNT_W'(1);
				end
			end
			CMD_READ: begin
				if (!pos_ok) begin
					res_nxt.status = ST_BADPOS;
				end else begin
					res_nxt.read_value = cells_q[cmd_s1.position[IDX_W-1:0]];
				end
			end
			CMD_FIND: begin
				// lowest matching index wins
				for (int i = DEPTH - 1; i >= 0; i--) begin
					if (CNT_W'(i) < count_q && cells_q[i] == cmd_s1.value) begin
						hit                 = 1'b1;
						res_nxt.found_index = IDX_W'(i);
					end
				end
				if (!hit) begin
					res_nxt.status = ST_NOTFOUND;
				end
			end
			CMD_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				count_nxt = count_q;
			end
		endcase
		res_nxt.entry_count = count_nxt;
		res_nxt.is_empty    = (count_nxt == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CNT_W'(DEPTH);
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (ctrl.exec) begin
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_s1 <= cmd;
		end
		if (ctrl.exec) begin
			res_q <= res_nxt;
		end
		if (ctrl.exec && wr_en) begin
			cells_q <= cells_nxt;
		end
	end

endmodule

[test/array_list_engine_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_engine_tb
// Self-checking bench for the array list engine. A short table of commands
// covers the field extremes, every command and the corner cases (full list,
// bad positions, capacity zero and below the count, missed finds, unknown
// kinds). Random command streams follow under several capacity settings,
// some above the depth. Every result is compared field by field against
// the table's expected values or a behavioural copy of the list in the bench.
// ----------------------------------------------------------------------------
module array_list_engine_tb;

	import ale_pkg::*;

	localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
	localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
	localparam int         PHASES         = 8;
	localparam int         PHASE_ITEMS    = 235;

	typedef struct {
		bit               is_cfg;
		logic [CNT_W-1:0] cfg_val;
		ale_in_t          item;
		bit               has_exp;
		ale_out_t         exp;
	} plan_row_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	ale_in_t          cmd;
	logic             busy;
	logic             done;
	ale_out_t         result;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	logic [ELEM_W-1:0] list_mem [DEPTH];
	logic [CNT_W-1:0]  list_count;
	logic [CNT_W-1:0]  capacity;
	ale_out_t          pending_results [$];
	plan_row_t         plan [$];
	int                fail_count;

	array_list_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8ms;
		$display("array_list_engine_tb NOT OK");
		$finish;
	end

	function automatic ale_out_t apply_command(ale_in_t c);
		ale_out_t r;
		int       eff;
		int       cnt;
		int       pos;
		bit       hit;
		r   = '0;
		cnt = list_count;
		pos = c.position;
		eff = (capacity > DEPTH) ? DEPTH : capacity;
		r.status = ST_OK;
		case (c.kind)
			CMD_INSERT: begin
				if (cnt >= eff) begin
					r.status = ST_FULL;
				end else if (pos > cnt) begin
					r.status = ST_BADPOS;
				end else begin
					for (int i = cnt; i > pos; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[pos] = c.value;
					cnt++;
				end
			end
			CMD_DELETE: begin
				if (cnt == 0 || pos >= cnt) begin
					r.status = ST_BADPOS;
				end else begin
					for (int i = pos; i + 1 < cnt; i++)
						list_mem[i] = list_mem[i+1];
					cnt--;
				end
			end
			CMD_READ: begin
				if (cnt == 0 || pos >= cnt)
					r.status = ST_BADPOS;
				else
					r.read_value = list_mem[pos];
			end
			CMD_FIND: begin
				hit = 1'b0;
				for (int i = 0; i < cnt && !hit; i++) begin
					if (list_mem[i] == c.value) begin
						hit           = 1'b1;
						r.found_index = i[IDX_W-1:0];
					end
				end
				if (!hit)
					r.status = ST_NOTFOUND;
			end
			CMD_CLEAR: begin
				cnt = 0;
			end
			default: begin
			end
		endcase
		list_count    = cnt[CNT_W-1:0];
		r.entry_count = list_count;
		r.is_empty    = (cnt == 0);
		return r;
	endfunction

	function automatic logic [ELEM_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3, 4, 5: return ELEM_W'($urandom_range(0, 3));
			default: return $urandom;
		endcase
	endfunction

	function automatic ale_in_t gen_command();
		ale_in_t c;
		int      k;
		int      cnt;
		cnt = list_count;
		k   = $urandom_range(0, 99);
		if (k < 40)
			c.kind = CMD_INSERT;
		else if (k < 60)
			c.kind = CMD_DELETE;
		else if (k < 78)
			c.kind = CMD_READ;
		else if (k < 93)
			c.kind = CMD_FIND;
		else if (k < 96)
			c.kind = CMD_CLEAR;
		else
			c.kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
		if ($urandom_range(0, 3) == 0)
			c.position = 5'($urandom_range(0, 31));
		else if (c.kind == CMD_INSERT || cnt == 0)
			c.position = 5'($urandom_range(0, cnt));
		else
			c.position = 5'($urandom_range(0, cnt - 1));
		if (c.kind == CMD_FIND && cnt > 0 && $urandom_range(0, 1) == 1)
			c.value = list_mem[$urandom_range(0, cnt - 1)];
		else
			c.value = pick_value();
		return c;
	endfunction

	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic void add_cmd(logic [2:0] kind, logic [CNT_W-1:0] pos,
			logic [ELEM_W-1:0] val, bit has_exp, logic [1:0] st,
			logic [ELEM_W-1:0] rd, logic [IDX_W-1:0] idx, logic [CNT_W-1:0] cnt);
		plan_row_t row;
		row.is_cfg            = 1'b0;
		row.cfg_val           = '0;
		row.item.kind         = kind;
		row.item.position     = pos;
		row.item.value        = val;
		row.has_exp           = has_exp;
		row.exp.status        = st;
		row.exp.read_value    = rd;
		row.exp.found_index   = idx;
		row.exp.entry_count   = cnt;
		row.exp.is_empty      = (cnt == 0);
		plan.push_back(row);
	endfunction

	function automatic void add_cfg(logic [CNT_W-1:0] v);
		plan_row_t row;
		row         = '{default: '0};
		row.is_cfg  = 1'b1;
		row.cfg_val = v;
		plan.push_back(row);
	endfunction

	task automatic send_command(ale_in_t c, int gap, bit has_exp, ale_out_t exp);
		ale_out_t predicted;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = apply_command(c);
		pending_results.push_back(has_exp ? exp : predicted);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CNT_W-1:0] v);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		capacity  = v;
	endtask

	task automatic check_field(string name, logic [ELEM_W-1:0] want,
			logic [ELEM_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		ale_out_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no item pending, expected none, actual %h",
					$time, result);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", ELEM_W'(want.status), ELEM_W'(result.status));
				check_field("read_value", want.read_value, result.read_value);
				check_field("found_index", ELEM_W'(want.found_index),
					ELEM_W'(result.found_index));
				check_field("entry_count", ELEM_W'(want.entry_count),
					ELEM_W'(result.entry_count));
				check_field("is_empty", ELEM_W'(want.is_empty), ELEM_W'(result.is_empty));
			end
		end
	end

	initial begin
		bit no_idle;
		fail_count = 0;
		list_count = '0;
		capacity   = 5'd16;
		for (int i = 0; i < DEPTH; i++)
			list_mem[i] = '0;
		start     <= 1'b0;
		cmd       <= '0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		arst_n    <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list
		add_cmd(CMD_READ,   5'd0,  32'h0,         1, ST_BADPOS,   32'h0,         4'd0, 5'd0);
		add_cmd(CMD_DELETE, 5'd0,  32'h0,         1, ST_BADPOS,   32'h0,         4'd0, 5'd0);
		add_cmd(CMD_FIND,   5'd0,  32'h0,         1, ST_NOTFOUND, 32'h0,         4'd0, 5'd0);
		add_cmd(CMD_INSERT, 5'd1,  32'h1234,      1, ST_BADPOS,   32'h0,         4'd0, 5'd0);
		// build and inspect
		add_cmd(CMD_INSERT, 5'd0,  32'h7fff_ffff, 1, ST_OK,       32'h0,         4'd0, 5'd1);
		add_cmd(CMD_INSERT, 5'd0,  32'h8000_0000, 1, ST_OK,       32'h0,         4'd0, 5'd2);
		add_cmd(CMD_INSERT, 5'd2,  32'h0,         1, ST_OK,       32'h0,         4'd0, 5'd3);
		add_cmd(CMD_INSERT, 5'd1,  32'h0f0f_0f0f, 0, ST_OK,       32'h0,         4'd0, 5'd0);
		add_cmd(CMD_READ,   5'd0,  32'h0,         1, ST_OK,       32'h8000_0000, 4'd0, 5'd4);
		add_cmd(CMD_READ,   5'd3,  32'h0,         1, ST_OK,       32'h0,         4'd0, 5'd4);
		add_cmd(CMD_READ,   5'd4,  32'h0,         1, ST_BADPOS,   32'h0,         4'd0, 5'd4);
		add_cmd(CMD_READ,   5'd31, 32'hffff_ffff, 1, ST_BADPOS,   32'h0,         4'd0, 5'd4);
		add_cmd(CMD_FIND,   5'd0,  32'h7fff_ffff, 1, ST_OK,       32'h0,         4'd2, 5'd4);
		add_cmd(CMD_INSERT, 5'd4,  32'h7fff_ffff, 0, ST_OK,       32'h0,         4'd0, 5'd0);
		add_cmd(CMD_FIND,   5'd0,  32'h7fff_ffff, 0, ST_OK,       32'h0,         4'd0, 5'd0);
		add_cmd(CMD_FIND,   5'd0,  32'h5,         1, ST_NOTFOUND, 32'h0,         4'd0, 5'd5);
		add_cmd(KIND_UNUSED_LO, 5'd0, 32'h0,      1, ST_OK,       32'h0,         4'd0, 5'd5);
		add_cmd(KIND_UNUSED_HI, 5'd31, 32'hffff_ffff, 1, ST_OK,   32'h0,         4'd0, 5'd5);
		add_cmd(CMD_DELETE, 5'd1,  32'h0,         0, ST_OK,       32'h0,         4'd0, 5'd0);
		add_cmd(CMD_DELETE, 5'd4,  32'h0,         1, ST_BADPOS,   32'h0,         4'd0, 5'd4);
		// capacity below the count
		add_cfg(5'd1);
		add_cmd(CMD_INSERT, 5'd0,  32'h1,         1, ST_FULL,     32'h0,         4'd0, 5'd4);
		add_cmd(CMD_INSERT, 5'd31, 32'h1,         1, ST_FULL,     32'h0,         4'd0, 5'd4);
		add_cmd(CMD_CLEAR,  5'd0,  32'h0,         1, ST_OK,       32'h0,         4'd0, 5'd0);
		add_cmd(CMD_INSERT, 5'd0,  32'h5a5a_5a5a, 1, ST_OK,       32'h0,         4'd0, 5'd1);
		add_cmd(CMD_INSERT, 5'd0,  32'h1,         1, ST_FULL,     32'h0,         4'd0, 5'd1);
		// capacity zero
		add_cfg(5'd0);
		add_cmd(CMD_DELETE, 5'd0,  32'h0,         1, ST_OK,       32'h0,         4'd0, 5'd0);
		add_cmd(CMD_INSERT, 5'd0,  32'h1,         1, ST_FULL,     32'h0,         4'd0, 5'd0);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_capacity(plan[i].cfg_val);
			else
				send_command(plan[i].item, gap_cycles(), plan[i].has_exp, plan[i].exp);
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: write_capacity(5'd31);
				1: write_capacity(5'd16);
				2: write_capacity(5'd1);
				3: write_capacity(5'd17);
				4: write_capacity(5'd0);
				5: write_capacity(5'd8);
				default: write_capacity(5'($urandom_range(0, 31)));
			endcase
			no_idle = 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0)
					no_idle = ($urandom_range(0, 3) == 0);
				if (n == PHASE_ITEMS / 2)
					drain_results();
				send_command(gen_command(), no_idle ? 0 : gap_cycles(), 1'b0, '0);
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("array_list_engine_tb OK");
		else
			$display("array_list_engine_tb NOT OK");
		$finish;
	end

endmodule
